@@ design/grm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the greedy rectangle merge block.
// No dependencies.
package grm_pkg;

    localparam int GRID_SIDE = 8;
    localparam int KEY_W     = 48;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int POS_W     = 4;
    localparam int CNT_W     = 5;
    localparam int MERGE_MAX = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_U_COUNT   = 2'd0;
    localparam logic [1:0] REG_V_COUNT   = 2'd1;
    localparam logic [1:0] REG_MAX_MERGE = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_O_RD,
        S_O_CHK,
        S_W_RD,
        S_W_CHK,
        S_H_RD,
        S_H_CHK,
        S_MARK,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        RD_ORIG,
        RD_WIDTH,
        RD_HEIGHT
    } t_rd_sel;

    typedef struct packed {
        logic [CNT_W-1:0] u_count;
        logic [CNT_W-1:0] v_count;
        logic [CNT_W-1:0] max_merge;
        logic             count_wr;
    } t_cfg;

    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    orig_take;
        logic    orig_next;
        logic    w_inc;
        logic    h_start;
        logic    du_inc;
        logic    h_inc;
        logic    mark;
        logic    flush;
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic orig_ok;
        logic orig_last;
        logic w_can;
        logic h_can;
        logic match;
        logic du_last;
        logic pend_valid;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CNT_W'(GRID_SIDE)) begin
            r = CNT_W'(GRID_SIDE);
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_merge(input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] r;
        if (m == '0) begin
            r = CNT_W'(1);
        end else if (m > CNT_W'(MERGE_MAX)) begin
            r = CNT_W'(MERGE_MAX);
        end else begin
            r = m;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_idx(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
        logic [8:0] t;
        t = 9'(row) * 9'(GRID_SIDE) + 9'(col);
        return t[CELL_W-1:0];
    endfunction

endpackage

@@ design/grm_regs.sv @@
`timescale 1ns / 1ps
// APB-style register file: u_count, v_count, max_merge.
// Depends on grm_pkg.
module grm_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [grm_pkg::ADDR_W-1:0] paddr,
    input  logic [grm_pkg::DATA_W-1:0] pwdata,
    output logic [grm_pkg::DATA_W-1:0] prdata,
    output grm_pkg::t_cfg             o_cfg
);
    import grm_pkg::*;

    logic [CNT_W-1:0] r_u_count;
    logic [CNT_W-1:0] r_v_count;
    logic [CNT_W-1:0] r_max_merge;
    logic             count_wr;
    logic             wr;

    assign wr = psel & penable & pwrite;
    assign count_wr = wr && ((paddr[3:2] == REG_U_COUNT) || (paddr[3:2] == REG_V_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_count   <= CNT_W'(8);
            r_v_count   <= CNT_W'(8);
            r_max_merge <= CNT_W'(16);
        end else begin
            if (wr) begin
                unique case (paddr[3:2])
                    REG_U_COUNT: begin
                        r_u_count <= pwdata[CNT_W-1:0];
                    end
                    REG_V_COUNT: begin
                        r_v_count <= pwdata[CNT_W-1:0];
                    end
                    REG_MAX_MERGE: begin
                        r_max_merge <= pwdata[CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_U_COUNT:   prdata = DATA_W'(r_u_count);
            REG_V_COUNT:   prdata = DATA_W'(r_v_count);
            REG_MAX_MERGE: prdata = DATA_W'(r_max_merge);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = '{u_count: r_u_count, v_count: r_v_count,
                     max_merge: r_max_merge, count_wr: count_wr};

endmodule

@@ design/grm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller FSM: load sequencing, rectangle growth and result flushing.
// Depends on grm_pkg.
module grm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  grm_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output grm_pkg::t_cmd o_cmd
);
    import grm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_ORIG;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.load_last) n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_O_RD;
            end
            S_O_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ORIG;
                n_state = S_O_CHK;
            end
            S_O_CHK: begin
                if (i_sts.orig_ok) begin
                    o_cmd.orig_take = 1'b1;
                    n_state = S_W_RD;
                end else if (i_sts.orig_last) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.orig_next = 1'b1;
                    n_state = S_O_RD;
                end
            end
            S_W_RD: begin
                if (i_sts.w_can) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_WIDTH;
                    n_state = S_W_CHK;
                end else begin
                    o_cmd.h_start = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_W_CHK: begin
                if (i_sts.match) begin
                    o_cmd.w_inc = 1'b1;
                    n_state = S_W_RD;
                end else begin
                    o_cmd.h_start = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_H_RD: begin
                if (i_sts.h_can) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEIGHT;
                    n_state = S_H_CHK;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_H_CHK: begin
                if (!i_sts.match) begin
                    n_state = S_MARK;
                end else if (i_sts.du_last) begin
                    o_cmd.h_inc = 1'b1;
                    n_state = S_H_RD;
                end else begin
                    o_cmd.du_inc = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_MARK: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.mark = 1'b1;
                    if (i_sts.orig_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.orig_next = 1'b1;
                        n_state = S_O_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

@@ design/grm_dp.sv @@
`timescale 1ns / 1ps
// Datapath: cell memory, used marks, scan counters, pending and output words.
// Depends on grm_pkg.
module grm_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  grm_pkg::t_cfg             i_cfg,
    input  grm_pkg::t_cmd             i_cmd,
    output grm_pkg::t_sts             o_sts,
    input  logic                      i_cell_valid,
    input  logic [grm_pkg::KEY_W-1:0] i_cell_key,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_quad_valid,
    output logic [grm_pkg::POS_W-1:0] o_quad_u,
    output logic [grm_pkg::POS_W-1:0] o_quad_v,
    output logic [grm_pkg::CNT_W-1:0] o_quad_width,
    output logic [grm_pkg::CNT_W-1:0] o_quad_height,
    output logic [grm_pkg::KEY_W-1:0] o_quad_key,
    output logic                      o_last_quad
);
    import grm_pkg::*;

    logic [CNT_W-1:0] uc, vc, mm;
    assign uc = eff_count(i_cfg.u_count);
    assign vc = eff_count(i_cfg.v_count);
    assign mm = eff_merge(i_cfg.max_merge);

    // load counters
    logic [POS_W-1:0] r_ld_row, r_ld_col;
    logic             ld_col_end, ld_row_end;
    assign ld_col_end = (CNT_W'(r_ld_col) + CNT_W'(1)) == uc;
    assign ld_row_end = (CNT_W'(r_ld_row) + CNT_W'(1)) == vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.count_wr) begin
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else if (i_cmd.load) begin
            if (ld_col_end) begin
                r_ld_col <= '0;
                r_ld_row <= ld_row_end ? '0 : r_ld_row + POS_W'(1);
            end else begin
                r_ld_col <= r_ld_col + POS_W'(1);
            end
        end
    end

    // scan counters
    logic [POS_W-1:0] r_u, r_v, r_du;
    logic [CNT_W-1:0] r_w, r_h;
    logic [KEY_W-1:0] r_okey;
    logic [KEY_W:0]   r_rd_data;
    logic             orig_col_end, orig_row_end;
    assign orig_col_end = (CNT_W'(r_u) + CNT_W'(1)) == uc;
    assign orig_row_end = (CNT_W'(r_v) + CNT_W'(1)) == vc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_u <= '0;
            r_v <= '0;
        end else if (i_cmd.orig_next) begin
            if (orig_col_end) begin
                r_u <= '0;
                r_v <= r_v + POS_W'(1);
            end else begin
                r_u <= r_u + POS_W'(1);
            end
        end
        if (i_cmd.orig_take) begin
            r_w    <= CNT_W'(1);
            r_h    <= CNT_W'(1);
            r_okey <= r_rd_data[KEY_W-1:0];
        end else begin
            if (i_cmd.w_inc) r_w <= r_w + CNT_W'(1);
            if (i_cmd.h_inc) r_h <= r_h + CNT_W'(1);
        end
        if (i_cmd.h_start || i_cmd.h_inc) begin
            r_du <= '0;
        end else if (i_cmd.du_inc) begin
            r_du <= r_du + POS_W'(1);
        end
    end

    // cell memory: valid flag above the key
    logic [KEY_W:0]    r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_addr;
    logic [CELL_W-1:0] rd_addr;
    logic [POS_W-1:0]  rd_row, rd_col;

    always_comb begin
        rd_row = r_v;
        rd_col = r_u;
        unique case (i_cmd.rd_sel)
            RD_ORIG: begin
                rd_row = r_v;
                rd_col = r_u;
            end
            RD_WIDTH: begin
                rd_row = r_v;
                rd_col = r_u + r_w[POS_W-1:0];
            end
            RD_HEIGHT: begin
                rd_row = r_v + r_h[POS_W-1:0];
                rd_col = r_u + r_du;
            end
            default: begin
                rd_row = r_v;
                rd_col = r_u;
            end
        endcase
    end
    assign rd_addr = cell_idx(rd_row, rd_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[cell_idx(r_ld_row, r_ld_col)] <= {i_cell_valid, i_cell_key};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // used marks
    logic [CELLS-1:0] r_used;
    logic [CELLS-1:0] rect_mask;
    logic [CNT_W:0]   u_end, v_end;
    assign u_end = (CNT_W+1)'(r_u) + (CNT_W+1)'(r_w);
    assign v_end = (CNT_W+1)'(r_v) + (CNT_W+1)'(r_h);

    for (genvar gi = 0; gi < CELLS; gi++) begin : g_mask
        localparam logic [CNT_W:0] ROW = (CNT_W+1)'(gi / GRID_SIDE);
        localparam logic [CNT_W:0] COL = (CNT_W+1)'(gi % GRID_SIDE);
        assign rect_mask[gi] = (COL >= (CNT_W+1)'(r_u)) && (COL < u_end) &&
                               (ROW >= (CNT_W+1)'(r_v)) && (ROW < v_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init) begin
            r_used <= '0;
        end else if (i_cmd.mark) begin
            r_used <= r_used | rect_mask;
        end
    end

    // pending rectangle and output word
    logic             r_pend_valid;
    logic [POS_W-1:0] r_pend_u, r_pend_v;
    logic [CNT_W-1:0] r_pend_w, r_pend_h;
    logic [KEY_W-1:0] r_pend_key;
    logic             push;
    assign push = (i_cmd.mark && r_pend_valid) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init || i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.mark) begin
            r_pend_valid <= 1'b1;
        end
        if (i_cmd.mark) begin
            r_pend_u   <= r_u;
            r_pend_v   <= r_v;
            r_pend_w   <= r_w;
            r_pend_h   <= r_h;
            r_pend_key <= r_okey;
        end
    end

    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            if (r_pend_valid) begin
                o_quad_valid  <= 1'b1;
                o_quad_u      <= r_pend_u;
                o_quad_v      <= r_pend_v;
                o_quad_width  <= r_pend_w;
                o_quad_height <= r_pend_h;
                o_quad_key    <= r_pend_key;
                o_last_quad   <= i_cmd.flush;
            end else begin
                o_quad_valid  <= 1'b0;
                o_quad_u      <= '0;
                o_quad_v      <= '0;
                o_quad_width  <= '0;
                o_quad_height <= '0;
                o_quad_key    <= '0;
                o_last_quad   <= 1'b1;
            end
        end
    end
    assign o_out_valid = r_out_valid;

    // status
    logic rd_used;
    assign rd_used = r_used[r_rd_addr];

    assign o_sts.load_last  = ld_col_end && ld_row_end;
    assign o_sts.orig_ok    = r_rd_data[KEY_W] && !rd_used;
    assign o_sts.orig_last  = orig_col_end && orig_row_end;
    assign o_sts.w_can      = (r_w < mm) && (u_end < (CNT_W+1)'(uc));
    assign o_sts.h_can      = (r_h < mm) && (v_end < (CNT_W+1)'(vc));
    assign o_sts.match      = r_rd_data[KEY_W] && !rd_used &&
                              (r_rd_data[KEY_W-1:0] == r_okey);
    assign o_sts.du_last    = (CNT_W'(r_du) + CNT_W'(1)) == r_w;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

@@ design/greedy_rectangle_merge_core.sv @@
`timescale 1ns / 1ps
// Greedy rectangle merge over one slice mask: top level.
// Depends on grm_pkg, grm_regs, grm_ctrl, grm_dp.
//
// Input channel (i_in_valid / o_in_ready): one cell word per transfer, row-major,
// u_count cells per row, v_count rows. Cells are taken one per cycle.
// After the last cell o_in_ready drops and the scan runs; no result appears
// for the other cells. Output channel (o_out_valid / i_out_ready): one word
// per rectangle, o_last_quad on the final one; an empty slice gives one
// word with o_quad_valid low.
// Scan steps: the used marks are cleared, then each origin is read from memory and checked,
// each probed neighbor cell is read and checked, a side that stops at the mask edge or the cap
// passes its read state without a read, each rectangle is marked and the last word is flushed.
// The single read port of the cell memory forces these reads one at a time. Rectangles are held
// one deep so last_quad can be set; output lags discovery by one rectangle.
// A stalled receiver holds the output register; the scan waits at the next
// rectangle until the register frees. Loading of the next slice starts once
// the final word is in the output register.
// Reset (synchronous, active low) returns to loading at cell 0 with
// u_count 8, v_count 8, max_merge 16. Writing u_count or v_count restarts
// the slice at cell 0. Registers must be written only while idle; the block itself does not enforce this.
module greedy_rectangle_merge_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [grm_pkg::ADDR_W-1:0] paddr,
    input  logic [grm_pkg::DATA_W-1:0] pwdata,
    output logic [grm_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cell_valid,
    input  logic [grm_pkg::KEY_W-1:0] i_cell_key,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_quad_valid,
    output logic [grm_pkg::POS_W-1:0] o_quad_u,
    output logic [grm_pkg::POS_W-1:0] o_quad_v,
    output logic [grm_pkg::CNT_W-1:0] o_quad_width,
    output logic [grm_pkg::CNT_W-1:0] o_quad_height,
    output logic [grm_pkg::KEY_W-1:0] o_quad_key,
    output logic                      o_last_quad
);
    import grm_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    grm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    grm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    grm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cell_valid  (i_cell_valid),
        .i_cell_key    (i_cell_key),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_quad_valid  (o_quad_valid),
        .o_quad_u      (o_quad_u),
        .o_quad_v      (o_quad_v),
        .o_quad_width  (o_quad_width),
        .o_quad_height (o_quad_height),
        .o_quad_key    (o_quad_key),
        .o_last_quad   (o_last_quad)
    );

endmodule

@@ design/grm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the greedy rectangle merge block, bound to the top.
// Depends on grm_pkg and greedy_rectangle_merge_core.
module grm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_quad_valid,
    input logic [grm_pkg::CNT_W-1:0] o_quad_width,
    input logic [grm_pkg::CNT_W-1:0] o_quad_height,
    input logic [grm_pkg::KEY_W-1:0] o_quad_key,
    input logic                      o_last_quad
);
    import grm_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_quad_key)
            && $stable(o_last_quad))
        else $error("stalled output word changed");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_quad_valid |-> o_last_quad && o_quad_width == '0
            && o_quad_height == '0 && o_quad_key == '0)
        else $error("bad empty-slice word");

    a_quad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_quad_valid |-> o_quad_width != '0 && o_quad_height != '0
            && o_quad_width <= CNT_W'(MERGE_MAX) && o_quad_height <= CNT_W'(MERGE_MAX))
        else $error("rectangle size out of range");

endmodule

bind greedy_rectangle_merge_core grm_checker u_grm_checker (.*);

@@ bench/grm_mesh_check.sv @@
`timescale 1ns / 1ps
// Scoreboard for greedy_rectangle_merge_core: follows register writes and cell words,
// predicts the rectangle words of each slice and checks them in order as they leave.
// Depends on grm_pkg.
module grm_mesh_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [grm_pkg::ADDR_W-1:0] i_paddr,
    input  logic [grm_pkg::DATA_W-1:0] i_pwdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_cell_valid,
    input  logic [grm_pkg::KEY_W-1:0]  i_cell_key,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_quad_valid,
    input  logic [grm_pkg::POS_W-1:0]  i_quad_u,
    input  logic [grm_pkg::POS_W-1:0]  i_quad_v,
    input  logic [grm_pkg::CNT_W-1:0]  i_quad_width,
    input  logic [grm_pkg::CNT_W-1:0]  i_quad_height,
    input  logic [grm_pkg::KEY_W-1:0]  i_quad_key,
    input  logic                       i_last_quad,
    output int                         o_errors,
    output int                         o_pending
);

    localparam int SIDE  = grm_pkg::GRID_SIDE;
    localparam int CELLS = grm_pkg::CELLS;
    localparam int KEY_W = grm_pkg::KEY_W;

    typedef struct packed {
        logic                      filled;
        logic [grm_pkg::POS_W-1:0] col;
        logic [grm_pkg::POS_W-1:0] row;
        logic [grm_pkg::CNT_W-1:0] width;
        logic [grm_pkg::CNT_W-1:0] height;
        logic [KEY_W-1:0]          key;
        logic                      last;
    } t_quad;

    logic [grm_pkg::CNT_W-1:0] u_reg;
    logic [grm_pkg::CNT_W-1:0] v_reg;
    logic [grm_pkg::CNT_W-1:0] merge_reg;
    int                        load_pos;
    logic                      mask_on    [CELLS];
    logic [KEY_W-1:0]          mask_key   [CELLS];
    logic                      mask_taken [CELLS];
    t_quad                     quads_due  [$];
    int                        mismatches = 0;

    function automatic int side_of(input logic [grm_pkg::CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > SIDE) return SIDE;
        return int'(c);
    endfunction

    function automatic int merge_cap(input logic [grm_pkg::CNT_W-1:0] m);
        if (m == 0) return 1;
        if (m > grm_pkg::MERGE_MAX) return grm_pkg::MERGE_MAX;
        return int'(m);
    endfunction

    function automatic logic joins(input int origin, input int cand);
        return mask_on[cand] && !mask_taken[cand] && mask_key[cand] == mask_key[origin];
    endfunction

    task automatic merge_slice();
        int    cols;
        int    rows;
        int    cap;
        int    w;
        int    h;
        int    base;
        int    found;
        logic  row_ok;
        t_quad q;
        cols  = side_of(u_reg);
        rows  = side_of(v_reg);
        cap   = merge_cap(merge_reg);
        found = 0;
        foreach (mask_taken[i]) mask_taken[i] = 1'b0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                base = r * SIDE + c;
                if (mask_on[base] && !mask_taken[base]) begin
                    w = 1;
                    h = 1;
                    while (w < cap && c + w < cols && joins(base, base + w)) w++;
                    row_ok = 1'b1;
                    while (row_ok && h < cap && r + h < rows) begin
                        for (int k = 0; k < w; k++) begin
                            if (!joins(base, (r + h) * SIDE + c + k)) row_ok = 1'b0;
                        end
                        if (row_ok) h++;
                    end
                    for (int dr = 0; dr < h; dr++) begin
                        for (int dc = 0; dc < w; dc++) begin
                            mask_taken[(r + dr) * SIDE + c + dc] = 1'b1;
                        end
                    end
                    q.filled = 1'b1;
                    q.col    = grm_pkg::POS_W'(c);
                    q.row    = grm_pkg::POS_W'(r);
                    q.width  = grm_pkg::CNT_W'(w);
                    q.height = grm_pkg::CNT_W'(h);
                    q.key    = mask_key[base];
                    q.last   = 1'b0;
                    quads_due.push_back(q);
                    found++;
                end
            end
        end
        if (found == 0) begin
            q      = '0;
            q.last = 1'b1;
        end else begin
            q      = quads_due.pop_back();
            q.last = 1'b1;
        end
        quads_due.push_back(q);
    endtask

    task automatic take_cell(input logic on, input logic [KEY_W-1:0] key);
        int cols;
        int total;
        int slot;
        cols  = side_of(u_reg);
        total = cols * side_of(v_reg);
        if (load_pos >= total) load_pos = 0;
        slot = (load_pos / cols) * SIDE + load_pos % cols;
        mask_on[slot]  = on;
        mask_key[slot] = key;
        load_pos++;
        if (load_pos >= total) begin
            load_pos = 0;
            merge_slice();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_quad want;
        if (!i_rst_n) begin
            u_reg     = grm_pkg::CNT_W'(SIDE);
            v_reg     = grm_pkg::CNT_W'(SIDE);
            merge_reg = grm_pkg::CNT_W'(grm_pkg::MERGE_MAX);
            load_pos  = 0;
            quads_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[grm_pkg::ADDR_W-1:2])
                    grm_pkg::REG_U_COUNT: begin
                        u_reg    = i_pwdata[grm_pkg::CNT_W-1:0];
                        load_pos = 0;
                    end
                    grm_pkg::REG_V_COUNT: begin
                        v_reg    = i_pwdata[grm_pkg::CNT_W-1:0];
                        load_pos = 0;
                    end
                    grm_pkg::REG_MAX_MERGE: begin
                        merge_reg = i_pwdata[grm_pkg::CNT_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_cell(i_cell_valid, i_cell_key);
            if (i_out_valid && i_out_ready) begin
                if (quads_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: expected no word, got valid %0b u %0d v %0d w %0d h %0d",
                             $time, i_quad_valid, i_quad_u, i_quad_v, i_quad_width,
                             i_quad_height);
                end else begin
                    want = quads_due.pop_front();
                    check_field("quad_valid", 64'(want.filled), 64'(i_quad_valid));
                    check_field("quad_u", 64'(want.col), 64'(i_quad_u));
                    check_field("quad_v", 64'(want.row), 64'(i_quad_v));
                    check_field("quad_width", 64'(want.width), 64'(i_quad_width));
                    check_field("quad_height", 64'(want.height), 64'(i_quad_height));
                    check_field("quad_key", 64'(want.key), 64'(i_quad_key));
                    check_field("last_quad", 64'(want.last), 64'(i_last_quad));
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= quads_due.size();
    end

endmodule

@@ bench/greedy_rectangle_merge_core_test.sv @@
`timescale 1ns / 1ps
// Testbench top for greedy_rectangle_merge_core: register setup, cell words, output stalls
// and the verdict. Depends on grm_pkg, the core and grm_mesh_check.
module greedy_rectangle_merge_core_test;

    localparam int SIDE          = grm_pkg::GRID_SIDE;
    localparam int KEY_W         = grm_pkg::KEY_W;
    localparam int CNT_W         = grm_pkg::CNT_W;
    localparam int DATA_W        = grm_pkg::DATA_W;
    localparam int ADDR_W        = grm_pkg::ADDR_W;
    localparam int RANDOM_CELLS  = 230;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum int {MASK_EMPTY, MASK_NOISE, MASK_PATCHES} t_mask_style;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [ADDR_W-1:0]         paddr        = '0;
    logic [DATA_W-1:0]         pwdata       = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic                      i_cell_valid = 1'b0;
    logic [KEY_W-1:0]          i_cell_key   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic                      o_quad_valid;
    logic [grm_pkg::POS_W-1:0] o_quad_u;
    logic [grm_pkg::POS_W-1:0] o_quad_v;
    logic [CNT_W-1:0]          o_quad_width;
    logic [CNT_W-1:0]          o_quad_height;
    logic [KEY_W-1:0]          o_quad_key;
    logic                      o_last_quad;

    int fails;
    int quads_waiting;
    int random_cells = 0;
    bit steady       = 1'b0;

    greedy_rectangle_merge_core dut (.*);

    grm_mesh_check quad_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cell_valid  (i_cell_valid),
        .i_cell_key    (i_cell_key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_quad_valid  (o_quad_valid),
        .i_quad_u      (o_quad_u),
        .i_quad_v      (o_quad_v),
        .i_quad_width  (o_quad_width),
        .i_quad_height (o_quad_height),
        .i_quad_key    (o_quad_key),
        .i_last_quad   (o_last_quad),
        .o_errors      (fails),
        .o_pending     (quads_waiting)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    function automatic int side_of(input logic [CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > SIDE) return SIDE;
        return int'(c);
    endfunction

    function automatic logic [CNT_W-1:0] pick_setting(input int nominal);
        logic [CNT_W-1:0] pick;
        case ($urandom_range(0, 7))
            0: pick = CNT_W'(0);
            1: pick = CNT_W'(1);
            2: pick = CNT_W'(nominal);
            3: pick = CNT_W'($urandom_range(nominal + 1, 31));
            default: pick = CNT_W'($urandom_range(1, nominal));
        endcase
        return pick;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: r = '0;
            1: r = '1;
            default: ;
        endcase
        return r[KEY_W-1:0];
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {(DATA_W - CNT_W)'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] u, input logic [CNT_W-1:0] v,
                             input logic [CNT_W-1:0] m);
        reg_write(grm_pkg::REG_U_COUNT, u);
        reg_write(grm_pkg::REG_V_COUNT, v);
        reg_write(grm_pkg::REG_MAX_MERGE, m);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (quads_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_cell(input logic on, input logic [KEY_W-1:0] key);
        i_in_valid   <= 1'b1;
        i_cell_valid <= on;
        i_cell_key   <= key;
        do @(posedge i_clk); while (!o_in_ready);
        if (!steady && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_slice(input int cols, input int rows);
        logic [KEY_W-1:0] palette [3];
        logic [KEY_W-1:0] above   [SIDE];
        logic [KEY_W-1:0] key;
        t_mask_style      style;
        int               kinds;
        kinds = $urandom_range(1, 3);
        case ($urandom_range(0, 9))
            0: style = MASK_EMPTY;
            1: style = MASK_NOISE;
            default: style = MASK_PATCHES;
        endcase
        foreach (palette[k]) palette[k] = random_key();
        foreach (above[k]) above[k] = palette[0];
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                case (style)
                    MASK_EMPTY: send_cell(1'b0, random_key());
                    MASK_NOISE: send_cell(1'($urandom), random_key());
                    default: begin
                        // lean on the cell above so patches grow in height too
                        key = ($urandom_range(0, 2) != 0) ? above[c]
                                                          : palette[$urandom_range(0, kinds - 1)];
                        above[c] = key;
                        send_cell($urandom_range(0, 99) < 88, key);
                    end
                endcase
                random_cells++;
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [CNT_W-1:0] u;
        logic [CNT_W-1:0] v;
        logic [CNT_W-1:0] m;
        int               total;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        quiesce();

        // zero counts and cap clamp to one: one-cell slices
        configure(5'd0, 5'd0, 5'd0);
        send_cell(1'b0, 48'h123456789ABC);
        send_cell(1'b1, '1);
        send_cell(1'b1, '0);
        quiesce();

        // oversized row clamps to grid side, width capped at 3; spare address ignored
        configure(5'd31, 5'd1, 5'd3);
        reg_write(REG_SPARE, 5'd1);
        repeat (8) send_cell(1'b1, 48'hA5A5_5A5A_C3C3);
        quiesce();

        configure(5'd3, 5'd2, 5'd31);
        repeat (6) send_cell(1'b1, '1);
        quiesce();

        // count rewrite restarts the slice, cap rewrite does not
        configure(5'd2, 5'd1, 5'd16);
        send_cell(1'b1, 48'h0000_FFFF_0000);
        quiesce();
        reg_write(grm_pkg::REG_U_COUNT, 5'd2);
        send_cell(1'b1, 48'h8000_0000_0001);
        send_cell(1'b1, 48'h8000_0000_0001);
        send_cell(1'b1, 48'h7FFF_FFFF_FFFE);
        quiesce();
        reg_write(grm_pkg::REG_MAX_MERGE, 5'd1);
        send_cell(1'b1, 48'h7FFF_FFFF_FFFE);
        quiesce();

        while (random_cells < RANDOM_CELLS) begin
            steady = (random_cells >= 90 && random_cells < 170);
            quiesce();
            u = pick_setting(SIDE);
            v = pick_setting(SIDE);
            m = pick_setting(grm_pkg::MERGE_MAX);
            configure(u, v, m);
            repeat ($urandom_range(1, 3)) send_slice(side_of(u), side_of(v));
            total = side_of(u) * side_of(v);
            if (total > 1 && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, total - 1)) begin
                    send_cell(1'($urandom), random_key());
                    random_cells++;
                end
            end
        end
        steady = 1'b0;
        quiesce();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
